>>> rtl/core/size_class_stack_pool_defines.svh
// Assertion macros shared by the stack pool RTL.
// Included by files that carry concurrent checks; no other dependencies.
// Checks compile away when SYNTHESIS is defined.
`ifndef SIZE_CLASS_STACK_POOL_DEFINES_SVH
`define SIZE_CLASS_STACK_POOL_DEFINES_SVH

`ifndef SYNTHESIS

`define SCP_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stack pool check failed");

`define SCP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stack pool check failed");

`else

`define SCP_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`define SCP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/scp_pkg.sv
// Shared constants, codes and types for the size-class stack pool.
// No dependencies; used by every module of the block.
package scp_pkg;

   localparam int NUM_CLASSES     = 6;
   localparam int CLASS_DEPTH     = 64;
   localparam int MIN_CLASS_BYTES = 2048;
   localparam int ADDR_BITS       = 48;

   localparam int SIZE_W      = 32;
   localparam int LIMIT_W     = 7;
   localparam int CLS_W       = $clog2(NUM_CLASSES + 1);
   localparam int CIDX_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CNT_W       = $clog2(CLASS_DEPTH + 1);
   localparam int PTR_W       = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
   localparam int STORE_DEPTH = NUM_CLASSES * CLASS_DEPTH;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      OUT_POOLED        = 3'd0,
      OUT_NEW_CLASS     = 3'd1,
      OUT_OVERSIZE      = 3'd2,
      OUT_PUSHED        = 3'd3,
      OUT_RELEASED_FULL = 3'd4,
      OUT_RELEASED_OVER = 3'd5,
      OUT_IGNORED       = 3'd6
   } outcome_type;

   typedef struct packed {
      logic                 wr_en;
      logic                 rd_en;
      logic [STORE_AW-1:0]  addr;
      logic [ADDR_BITS-1:0] wdata;
   } store_req_type;

endpackage

>>> rtl/core/scp_class_map.sv
// Maps a byte size to its power-of-two size class and the class size in bytes.
// Depends on scp_pkg.
module scp_class_map (
   input  logic [scp_pkg::SIZE_W-1:0] size,
   output logic [scp_pkg::CLS_W-1:0]  size_class,
   output logic [scp_pkg::SIZE_W-1:0] class_bytes
);

   logic [63:0] bound;
   logic [63:0] cls_bytes64;

   // smallest class whose bound covers the size; independent compares, priority pick
   always_comb begin
      size_class  = scp_pkg::CLS_W'(scp_pkg::NUM_CLASSES);
      cls_bytes64 = '0;
      bound       = '0;
      for (int i = scp_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
         bound = 64'(scp_pkg::MIN_CLASS_BYTES) << i;
         if ({32'd0, size} <= bound) begin
            size_class  = scp_pkg::CLS_W'(i);
            cls_bytes64 = bound;
         end
      end
   end

   assign class_bytes = cls_bytes64[scp_pkg::SIZE_W-1:0];

endmodule

>>> rtl/core/scp_store.sv
// Free-address store: one synchronous RAM holding every class's LIFO.
// One access per cycle, read data registered. Depends on scp_pkg.
module scp_store (
   input  logic                          clock,
   input  scp_pkg::store_req_type        req,
   output logic [scp_pkg::ADDR_BITS-1:0] rd_data
);

   logic [scp_pkg::ADDR_BITS-1:0] mem [scp_pkg::STORE_DEPTH];
   logic [scp_pkg::ADDR_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.addr] <= req.wdata;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/size_class_stack_pool.sv
// Top level of the size-class stack pool: request decode, per-class counts,
// limit register and result registers. Depends on scp_pkg, scp_class_map,
// scp_store and size_class_stack_pool_defines.svh.
//
// An item is taken when start is high and busy is low; its result appears on
// the rsp_ ports for one cycle, flagged by rsp_valid, in the cycle after it is
// taken, and the receiver cannot stall it. Each item has an accept cycle,
// which reads or writes the free-address RAM, and a result cycle, which
// shows the RAM's registered read data (busy is high there).
// Counts live in flip-flops and clear at reset, so no clearing pass is needed.
`include "size_class_stack_pool_defines.svh"

module size_class_stack_pool (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_op,
   input  logic [scp_pkg::SIZE_W-1:0]          req_size,
   input  logic [scp_pkg::ADDR_BITS-1:0]       req_top_address,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_outcome,
   output logic [scp_pkg::ADDR_BITS-1:0]       rsp_address,
   output logic [scp_pkg::SIZE_W-1:0]          rsp_backing_size,
   output logic [scp_pkg::CLS_W-1:0]           rsp_size_class,
   input  logic                                csr_wr_en,
   input  logic [scp_pkg::LIMIT_W-1:0]         csr_wr_data
);

   logic                          accept;
   logic [scp_pkg::CLS_W-1:0]     cls_num;
   logic [scp_pkg::CIDX_W-1:0]    cls_idx;
   logic [scp_pkg::SIZE_W-1:0]    class_bytes;
   logic                          in_pool;
   logic [scp_pkg::CNT_W-1:0]     cur_cnt;
   logic [scp_pkg::CNT_W-1:0]     eff_limit;
   logic [scp_pkg::CNT_W-1:0]     slot;
   logic                          push;
   logic                          pop;
   logic                          cnt_ok;
   logic                          rsp_oversize;
   logic                          rsp_beyond_pool;

   logic [scp_pkg::LIMIT_W-1:0]   limit_ff;
   logic [scp_pkg::CNT_W-1:0]     cnt_ff [scp_pkg::NUM_CLASSES];
   logic [scp_pkg::CNT_W-1:0]     cnt_in [scp_pkg::NUM_CLASSES];

   logic                          rsp_valid_ff;
   logic                          pooled_ff;
   scp_pkg::outcome_type          outcome_ff, outcome_in;
   logic [scp_pkg::ADDR_BITS-1:0] addr_ff, addr_in;
   logic [scp_pkg::SIZE_W-1:0]    bsize_ff, bsize_in;
   logic [scp_pkg::CLS_W-1:0]     class_ff, class_in;

   scp_pkg::store_req_type        store_req;
   logic [scp_pkg::ADDR_BITS-1:0] store_rd_data;

   assign accept = start & ~busy;
   assign busy   = rsp_valid_ff;

   scp_class_map u_class_map (
      .size        (req_size),
      .size_class  (cls_num),
      .class_bytes (class_bytes)
   );

   assign in_pool = (cls_num != scp_pkg::CLS_W'(scp_pkg::NUM_CLASSES));
   assign cls_idx = cls_num[scp_pkg::CIDX_W-1:0];
   assign cur_cnt = cnt_ff[cls_idx];

   always_comb begin
      if (int'(limit_ff) > scp_pkg::CLASS_DEPTH) begin
         eff_limit = scp_pkg::CNT_W'(scp_pkg::CLASS_DEPTH);
      end else begin
         eff_limit = scp_pkg::CNT_W'(limit_ff);
      end
   end

   always_comb begin
      outcome_in = scp_pkg::OUT_IGNORED;
      addr_in    = '0;
      bsize_in   = '0;
      class_in   = cls_num;
      push       = 1'b0;
      pop        = 1'b0;
      if (req_op == scp_pkg::OP_ALLOC) begin
         if (!in_pool) begin
            outcome_in = scp_pkg::OUT_OVERSIZE;
            bsize_in   = req_size;
         end else if (cur_cnt != '0) begin
            outcome_in = scp_pkg::OUT_POOLED;
            pop        = 1'b1;
         end else begin
            outcome_in = scp_pkg::OUT_NEW_CLASS;
            bsize_in   = class_bytes;
         end
      end else if (req_top_address == '0) begin
         // null free leaves state alone
         class_in = '0;
      end else begin
         addr_in = req_top_address;
         if (!in_pool) begin
            outcome_in = scp_pkg::OUT_RELEASED_OVER;
            bsize_in   = req_size;
         end else if (cur_cnt >= eff_limit) begin
            outcome_in = scp_pkg::OUT_RELEASED_FULL;
            bsize_in   = req_size;
         end else begin
            outcome_in = scp_pkg::OUT_PUSHED;
            push       = 1'b1;
         end
      end
   end

   // pop reads the top entry, push writes one above it
   assign slot = pop ? (cur_cnt - scp_pkg::CNT_W'(1)) : cur_cnt;

   always_comb begin
      store_req.wr_en = accept & push;
      store_req.rd_en = accept & pop;
      store_req.addr  = scp_pkg::STORE_AW'(cls_idx) * scp_pkg::STORE_AW'(scp_pkg::CLASS_DEPTH)
                        + scp_pkg::STORE_AW'(slot[scp_pkg::PTR_W-1:0]);
      store_req.wdata = req_top_address;
   end

   scp_store u_store (
      .clock   (clock),
      .req     (store_req),
      .rd_data (store_rd_data)
   );

   always_comb begin
      for (int i = 0; i < scp_pkg::NUM_CLASSES; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      if (accept && push) begin
         cnt_in[cls_idx] = cur_cnt + scp_pkg::CNT_W'(1);
      end else if (accept && pop) begin
         cnt_in[cls_idx] = cur_cnt - scp_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= scp_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < scp_pkg::NUM_CLASSES; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         rsp_valid_ff <= accept;
         for (int i = 0; i < scp_pkg::NUM_CLASSES; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         outcome_ff <= outcome_in;
         addr_ff    <= addr_in;
         bsize_ff   <= bsize_in;
         class_ff   <= class_in;
         pooled_ff  <= pop;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = outcome_ff;
   assign rsp_address      = pooled_ff ? store_rd_data : addr_ff;
   assign rsp_backing_size = bsize_ff;
   assign rsp_size_class   = class_ff;

   always_comb begin
      cnt_ok = 1'b1;
      for (int i = 0; i < scp_pkg::NUM_CLASSES; i++) begin
         if (int'(cnt_ff[i]) > scp_pkg::CLASS_DEPTH) begin
            cnt_ok = 1'b0;
         end
      end
   end

   assign rsp_oversize    = rsp_valid && (outcome_ff == scp_pkg::OUT_OVERSIZE ||
                                          outcome_ff == scp_pkg::OUT_RELEASED_OVER);
   assign rsp_beyond_pool = (rsp_size_class == scp_pkg::CLS_W'(scp_pkg::NUM_CLASSES));

   `SCP_ASSERT_NEXT(a_rsp_follows_accept, clock, reset, accept, rsp_valid)
   `SCP_ASSERT_IMPL(a_rsp_only_after_accept, clock, reset, rsp_valid, $past(accept))
   `SCP_ASSERT_IMPL(a_oversize_class, clock, reset, rsp_oversize, rsp_beyond_pool)
   `SCP_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, cnt_ok)

endmodule
